[hdl/skf_pkg.sv]
// Shared types and constants for the scalar Kalman filter.
// No dependencies; used by skf_gain_div and scalar_kalman_filter_top.
`default_nettype none

package skf_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned QUO_W  = GAIN_W + 1;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd6554;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd13107;

  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] p;
    logic [DATA_W:0]   s;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/scalar_kalman_filter_top.sv]
// Top level of the scalar random-walk Kalman filter with APB-style register port.
// Depends on skf_pkg and skf_gain_div.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / measurement_i) takes one signed Q16.16
//   sample per transaction. Output channel (out_valid_o / out_ready_i) returns the
//   saturated estimate and updated covariance for that sample, one transaction each.
//   Registers: process_noise at byte address 0, measure_noise at byte address 4,
//   written through psel/penable/pwrite; reads return them. The user must write
//   them only while the filter is idle; the block itself does not enforce this.
//   The restoring gain divider dominates the time from the input transaction to
//   out_valid_o; one shared multiplier forms the estimate correction and the
//   covariance product in turn. New samples are taken only while idle.
//   The filter accepts a new sample while a finished result still waits on the
//   output register; if a second result is ready before the first is taken, the
//   filter holds in its last step until the output register frees.
//   Reset: estimate and covariance clear to zero, the noise registers return to
//   0.1 and 0.2 in Q16.16, and both channels go idle.
`default_nettype none

module scalar_kalman_filter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] measurement_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      estimate_o,
  output logic [31:0]      covariance_o
);

  localparam int unsigned W  = skf_pkg::DATA_W;
  localparam int unsigned MA = W + 2;
  localparam int unsigned MB = skf_pkg::GAIN_W + 2;
  localparam int unsigned MP = MA + MB;
  localparam int unsigned PW = W + skf_pkg::GAIN_W + 1;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SUM     = 3'd1;
  localparam logic [2:0] ST_DIV     = 3'd2;
  localparam logic [2:0] ST_MUL_EST = 3'd3;
  localparam logic [2:0] ST_EST     = 3'd4;
  localparam logic [2:0] ST_MUL_COV = 3'd5;
  localparam logic [2:0] ST_COV     = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [W-1:0]                  pn_q, mn_q;
  logic [W-1:0]                  est_q, est_d;
  logic [W-1:0]                  cov_q, cov_d;
  logic [W-1:0]                  p_q, p_d;
  logic [W:0]                    y_q, y_d;
  logic [skf_pkg::GAIN_W-1:0]    k_q, k_d;
  logic [PW-1:0]                 prod_q, prod_d;
  logic                          out_valid_q, out_valid_d;
  logic [W-1:0]                  out_est_q, out_est_d;
  logic [W-1:0]                  out_cov_q, out_cov_d;

  skf_pkg::div_req_t div_req;
  skf_pkg::div_rsp_t div_rsp;

  logic                          cfg_wr;
  logic [W:0]                    p_sum;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [MP-1:0]          mul_p;
  logic [skf_pkg::GAIN_W:0]      one_minus_k;
  logic [W:0]                    d_val;
  logic [W+1:0]                  e_sum;
  logic [W-1:0]                  e_sat;
  logic                          out_free;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == skf_pkg::REG_MEASURE_NOISE) ? mn_q : pn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= skf_pkg::PROCESS_NOISE_RST;
      mn_q <= skf_pkg::MEASURE_NOISE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == skf_pkg::REG_PROCESS_NOISE) begin
        pn_q <= pwdata;
      end else begin
        mn_q <= pwdata;
      end
    end
  end

  skf_gain_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    one_minus_k = (skf_pkg::GAIN_W+1)'(1) << skf_pkg::GAIN_W;
    one_minus_k = one_minus_k - {1'b0, k_q};
    if (state_q == ST_MUL_EST) begin
      mul_a = {y_q[W], y_q};
      mul_b = {2'b00, k_q};
    end else begin
      mul_a = {2'b00, p_q};
      mul_b = {1'b0, one_minus_k};
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    p_sum = {1'b0, cov_q} + {1'b0, pn_q};
    d_val = prod_q[PW-1:skf_pkg::GAIN_W];
    e_sum = {{2{est_q[W-1]}}, est_q} + {d_val[W], d_val};
    if (!e_sum[W+1] && (e_sum[W] || e_sum[W-1])) begin
      e_sat = {1'b0, {(W-1){1'b1}}};
    end else if (e_sum[W+1] && !(e_sum[W] && e_sum[W-1])) begin
      e_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      e_sat = e_sum[W-1:0];
    end
  end

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d     = state_q;
    est_d       = est_q;
    cov_d       = cov_q;
    p_d         = p_q;
    y_d         = y_q;
    k_d         = k_q;
    prod_d      = prod_q;
    out_est_d   = out_est_q;
    out_cov_d   = out_cov_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    div_req.start = 1'b0;
    div_req.p     = p_q;
    div_req.s     = {1'b0, p_q} + {1'b0, mn_q};

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          p_d     = p_sum[W] ? {W{1'b1}} : p_sum[W-1:0];
          y_d     = {measurement_i[W-1], measurement_i} - {est_q[W-1], est_q};
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          k_d     = div_rsp.gain;
          state_d = ST_MUL_EST;
        end
      end
      ST_MUL_EST: begin
        prod_d  = mul_p[PW-1:0];
        state_d = ST_EST;
      end
      ST_EST: begin
        est_d   = e_sat;
        state_d = ST_MUL_COV;
      end
      ST_MUL_COV: begin
        prod_d  = mul_p[PW-1:0];
        state_d = ST_COV;
      end
      ST_COV: begin
        if (out_free) begin
          cov_d       = prod_q[W+skf_pkg::GAIN_W-1:skf_pkg::GAIN_W];
          out_cov_d   = prod_q[W+skf_pkg::GAIN_W-1:skf_pkg::GAIN_W];
          out_est_d   = est_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      est_q       <= '0;
      cov_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      est_q       <= est_d;
      cov_q       <= cov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q       <= p_d;
    y_q       <= y_d;
    k_q       <= k_d;
    prod_q    <= prod_d;
    out_est_q <= out_est_d;
    out_cov_q <= out_cov_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign estimate_o   = out_est_q;
  assign covariance_o = out_cov_q;

endmodule

`default_nettype wire

[hdl/skf_gain_div.sv]
// Restoring divider for the Kalman gain: floor(P * 2^16 / S), one quotient bit per cycle.
// Depends on skf_pkg for widths, request and response types.
`default_nettype none

module skf_gain_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire skf_pkg::div_req_t req_i,
  output skf_pkg::div_rsp_t     rsp_o
);

  localparam int unsigned CNT_W = $clog2(skf_pkg::QUO_W + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [skf_pkg::DATA_W+1:0] rem_q, rem_d;
  logic [skf_pkg::DATA_W:0]   s_q, s_d;
  logic [skf_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic                       zero_q, zero_d;

  logic [skf_pkg::DATA_W+2:0] trial;
  logic                       ge;
  logic [skf_pkg::DATA_W+1:0] rem_nx;

  always_comb begin
    trial  = {1'b0, rem_q} - {2'b00, s_q};
    ge     = ~trial[skf_pkg::DATA_W+2];
    rem_nx = ge ? trial[skf_pkg::DATA_W+1:0] : rem_q;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    s_d    = s_q;
    quo_d  = quo_q;
    zero_d = zero_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(skf_pkg::QUO_W);
      rem_d  = {2'b00, req_i.p};
      s_d    = req_i.s;
      quo_d  = '0;
      zero_d = (req_i.s == '0);
    end else if (busy_q) begin
      rem_d = {rem_nx[skf_pkg::DATA_W:0], 1'b0};
      quo_d = {quo_q[skf_pkg::QUO_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    s_q    <= s_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
  end

  always_comb begin
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.gain = '0;
    end else if (quo_q[skf_pkg::QUO_W-1]) begin
      rsp_o.gain = skf_pkg::GAIN_MAX;
    end else begin
      rsp_o.gain = quo_q[skf_pkg::GAIN_W-1:0];
    end
  end

endmodule

`default_nettype wire
